// ----- rtl/core/olt_pkg.sv -----
`timescale 1ns / 1ps

package olt_pkg;

  // Default table size
  localparam int unsigned TableEntriesDef = 64;

  // Field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned ObjW    = 32;
  localparam int unsigned SessW   = 64;
  localparam int unsigned StatusW = 2;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InRawW   = FuncW + ObjW + SessW;
  localparam int unsigned InDataW  = ((InRawW + 7) / 8) * 8;
  localparam int unsigned OutRawW  = StatusW + 1 + SessW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [FuncW-1:0] {
    FN_LOCK   = 2'd0,
    FN_UNLOCK = 2'd1,
    FN_QUERY  = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_SUCCESS   = 2'd0,
    ST_NO_ACCESS = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Search token that walks the cell chain
  typedef struct packed {
    logic             vld;
    logic [FuncW-1:0] func;
    logic [ObjW-1:0]  obj;
    logic [SessW-1:0] sess;
    logic             hit;
    logic [SessW-1:0] own;
    logic             free;
  } tok_t;

  // Table update broadcast to all cells
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [ObjW-1:0]  obj;
    logic [SessW-1:0] own;
  } commit_t;

endpackage

// ----- rtl/core/olt_cell.sv -----
`timescale 1ns / 1ps

module olt_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  olt_pkg::tok_t         tok_i,
  input  logic [IDX_W-1:0]      hit_idx_i,
  input  logic [IDX_W-1:0]      free_idx_i,
  output olt_pkg::tok_t         tok_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  output logic [IDX_W-1:0]      free_idx_o,
  input  olt_pkg::commit_t      cmt_i,
  input  logic [IDX_W-1:0]      cmt_idx_i
);
  import olt_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic             valid_q;
  logic [ObjW-1:0]  obj_q;
  logic [SessW-1:0] own_q;

  tok_t             tok_d, tok_q;
  logic [IDX_W-1:0] hidx_d, hidx_q, fidx_d, fidx_q;
  logic             match;
  logic             sel;

  // Compare this entry with the passing token
  assign match = valid_q && (obj_q == tok_i.obj);

  always_comb begin
    tok_d  = tok_i;
    hidx_d = hit_idx_i;
    fidx_d = free_idx_i;
    if (!tok_i.hit && match) begin
      tok_d.hit = 1'b1;
      tok_d.own = own_q;
      hidx_d    = MyIdx;
    end
    if (!tok_i.free && !valid_q) begin
      tok_d.free = 1'b1;
      fidx_d     = MyIdx;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hidx_q     <= hidx_d;
    fidx_q     <= fidx_d;
  end

  assign tok_o      = tok_q;
  assign hit_idx_o  = hidx_q;
  assign free_idx_o = fidx_q;

  // Apply insert or removal addressed to this cell
  assign sel = (cmt_idx_i == MyIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel && cmt_i.wr) begin
      valid_q <= 1'b1;
    end else if (sel && cmt_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && cmt_i.wr) begin
      obj_q <= cmt_i.obj;
      own_q <= cmt_i.own;
    end
  end

endmodule

// ----- rtl/core/object_lock_table.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Item fields (low bit up)
// s_axis   | in  | func[1:0], object_id[33:2], session_id[97:34], zero pad to 104
// m_axis   | out | status[1:0], locked[2], owner_session[66:3], zero pad to 72
//
// An accepted item walks the chain of TABLE_ENTRIES cells, one cell per cycle,
// then is decided and its table update is applied. The result waits in a pending
// register until it moves into the output register. One item is searched at a
// time; the next one is taken once the previous result has moved into the
// output register.
// Reset clears every entry's valid bit at once; no clearing pass is needed.
// A stalled output holds its item while the next search goes on.

module object_lock_table #(
  parameter int unsigned TABLE_ENTRIES = olt_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // func[1:0], object_id[33:2], session_id[97:34]
  input  logic [olt_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], locked[2], owner_session[66:3]
  output logic [olt_pkg::OutDataW-1:0]  m_axis_tdata
);
  import olt_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  tok_t            tok_w   [TABLE_ENTRIES];
  logic [IdxW-1:0] hidx_w  [TABLE_ENTRIES];
  logic [IdxW-1:0] fidx_w  [TABLE_ENTRIES];
  tok_t            launch;
  commit_t         cmt;
  logic [IdxW-1:0] cmt_idx;
  logic            accept;
  logic            busy_q;

  tok_t             last;
  status_e          res_status;
  logic             res_locked;
  logic [SessW-1:0] res_owner;

  logic                pend_v_q;
  logic [OutRawW-1:0]  pend_q;
  logic                out_v_q;
  logic [OutRawW-1:0]  out_q;
  logic                move;

  // Launch a token into the first cell
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    launch      = '0;
    launch.vld  = accept;
    launch.func = s_axis_tdata[FuncW-1:0];
    launch.obj  = s_axis_tdata[FuncW +: ObjW];
    launch.sess = s_axis_tdata[FuncW+ObjW +: SessW];
  end

  // Cell chain
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      olt_cell #(.IDX_W(IdxW), .CELL_IDX(i)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (launch),
        .hit_idx_i  ('0),
        .free_idx_i ('0),
        .tok_o      (tok_w[i]),
        .hit_idx_o  (hidx_w[i]),
        .free_idx_o (fidx_w[i]),
        .cmt_i      (cmt),
        .cmt_idx_i  (cmt_idx)
      );
    end else begin : g_body
      olt_cell #(.IDX_W(IdxW), .CELL_IDX(i)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (tok_w[i-1]),
        .hit_idx_i  (hidx_w[i-1]),
        .free_idx_i (fidx_w[i-1]),
        .tok_o      (tok_w[i]),
        .hit_idx_o  (hidx_w[i]),
        .free_idx_o (fidx_w[i]),
        .cmt_i      (cmt),
        .cmt_idx_i  (cmt_idx)
      );
    end
  end

  // Decide the request once its token leaves the last cell
  assign last = tok_w[TABLE_ENTRIES-1];

  always_comb begin
    res_status = ST_SUCCESS;
    res_locked = 1'b0;
    res_owner  = '0;
    cmt        = '0;
    cmt.obj    = last.obj;
    cmt.own    = last.sess;
    cmt_idx    = hidx_w[TABLE_ENTRIES-1];
    case (last.func)
      FN_LOCK: begin
        if (last.hit) begin
          res_locked = 1'b1;
          res_owner  = last.own;
          res_status = (last.own == last.sess) ? ST_SUCCESS : ST_NO_ACCESS;
        end else if (last.free) begin
          cmt.wr     = last.vld;
          cmt_idx    = fidx_w[TABLE_ENTRIES-1];
          res_locked = 1'b1;
          res_owner  = last.sess;
        end else begin
          res_status = ST_FULL;
        end
      end
      FN_UNLOCK: begin
        if (!last.hit) begin
          res_status = ST_NOT_FOUND;
        end else if (last.own != last.sess) begin
          res_status = ST_NO_ACCESS;
          res_locked = 1'b1;
          res_owner  = last.own;
        end else begin
          cmt.clr   = last.vld;
          res_owner = last.own;
        end
      end
      default: begin
        res_locked = last.hit;
        res_owner  = last.hit ? last.own : '0;
      end
    endcase
  end

  // Hold the decided result until the output register is free
  assign move = pend_v_q && (!out_v_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (last.vld) begin
        pend_v_q <= 1'b1;
      end else if (move) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.vld) begin
      pend_q <= {res_owner, res_locked, res_status};
    end
    if (move) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutDataW - OutRawW){1'b0}}, out_q};

endmodule

// ----- dv/object_lock_table_tb.sv -----
`timescale 1ns / 1ps

module object_lock_table_tb;
  import olt_pkg::*;

  localparam int unsigned Entries = TableEntriesDef;
  localparam int unsigned SearchCycles = Entries + 2;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAtItem = 300;
  localparam int unsigned PoolObjs = 96;
  localparam int unsigned PoolSess = 4;
  localparam int unsigned FillItems = 110;
  localparam int unsigned ChurnItems = 580;
  localparam int unsigned DrainItems = 110;

  // Opcode 3 is not defined by the package; it behaves like a query
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam logic [ObjW-1:0] ObjMax = '1;
  localparam logic [SessW-1:0] SessMax = '1;
  localparam logic [ObjW-1:0] ObjA = 32'hA5A5_5A5A;
  localparam logic [ObjW-1:0] ObjB = 32'h5A5A_A5A5;
  localparam logic [SessW-1:0] SessA = 64'h0123_4567_89AB_CDEF;
  localparam logic [SessW-1:0] SessB = 64'hFEDC_BA98_7654_3210;

  typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN} stim_phase_e;

  typedef struct {
    status_e          status;
    logic             locked;
    logic [SessW-1:0] owner;
  } lock_result_t;

  typedef struct {
    logic [FuncW-1:0] fn;
    logic [ObjW-1:0]  obj;
    logic [SessW-1:0] sess;
    bit               fixed;
    lock_result_t     res;
  } lock_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the lock table
  logic             shadow_valid [Entries];
  logic [ObjW-1:0]  shadow_obj   [Entries];
  logic [SessW-1:0] shadow_owner [Entries];

  lock_result_t     pending_results[$];
  logic [ObjW-1:0]  obj_pool [PoolObjs];
  logic [SessW-1:0] sess_pool[PoolSess];
  int unsigned      items_sent = 0;
  int unsigned      fill_idx = 0;
  int unsigned      err_count = 0;
  bit               quiet = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;

  // Directed requests; typed results are the ones obvious from the rules
  lock_row_t lock_rows[20] = '{
    '{FN_QUERY,   '0,     '0,      1'b1, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_UNLOCK,  '0,     '0,      1'b1, '{ST_NOT_FOUND, 1'b0, '0}},
    '{FN_LOCK,    '0,     '0,      1'b1, '{ST_SUCCESS,   1'b1, '0}},
    '{FN_LOCK,    ObjMax, SessMax, 1'b1, '{ST_SUCCESS,   1'b1, SessMax}},
    '{FN_LOCK,    '0,     SessMax, 1'b1, '{ST_NO_ACCESS, 1'b1, '0}},
    '{FN_UNLOCK,  '0,     SessMax, 1'b1, '{ST_NO_ACCESS, 1'b1, '0}},
    '{FN_QUERY,   ObjMax, '0,      1'b1, '{ST_SUCCESS,   1'b1, SessMax}},
    '{FuncUnused, ObjMax, '0,      1'b1, '{ST_SUCCESS,   1'b1, SessMax}},
    '{FN_LOCK,    ObjMax, SessMax, 1'b1, '{ST_SUCCESS,   1'b1, SessMax}},
    '{FN_UNLOCK,  ObjMax, SessMax, 1'b1, '{ST_SUCCESS,   1'b0, SessMax}},
    '{FN_QUERY,   ObjMax, SessMax, 1'b1, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_UNLOCK,  '0,     '0,      1'b1, '{ST_SUCCESS,   1'b0, '0}},
    '{FuncUnused, '0,     SessMax, 1'b1, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_LOCK,    ObjA,   SessA,   1'b0, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_LOCK,    ObjB,   SessB,   1'b0, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_LOCK,    ObjA,   SessB,   1'b0, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_UNLOCK,  ObjB,   SessA,   1'b0, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_QUERY,   ObjA,   SessB,   1'b0, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_UNLOCK,  ObjB,   SessB,   1'b0, '{ST_SUCCESS,   1'b0, '0}},
    '{FN_UNLOCK,  ObjA,   SessA,   1'b0, '{ST_SUCCESS,   1'b0, '0}}
  };

  object_lock_table #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Decide one request against the shadow table and update it
  function automatic lock_result_t apply_lock_request(logic [FuncW-1:0] fn,
                                                      logic [ObjW-1:0] obj,
                                                      logic [SessW-1:0] sess);
    lock_result_t r;
    int hit;
    int slot;
    hit = -1;
    slot = -1;
    for (int i = 0; i < Entries; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_obj[i] == obj) hit = i;
      if (slot < 0 && !shadow_valid[i]) slot = i;
    end
    r = '{ST_SUCCESS, 1'b0, '0};
    case (fn)
      FN_LOCK: begin
        if (hit >= 0) begin
          r.owner = shadow_owner[hit];
          r.locked = 1'b1;
          r.status = (shadow_owner[hit] == sess) ? ST_SUCCESS : ST_NO_ACCESS;
        end else if (slot >= 0) begin
          shadow_valid[slot] = 1'b1;
          shadow_obj[slot] = obj;
          shadow_owner[slot] = sess;
          r.owner = sess;
          r.locked = 1'b1;
        end else begin
          r.status = ST_FULL;
        end
      end
      FN_UNLOCK: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (shadow_owner[hit] != sess) begin
          r.status = ST_NO_ACCESS;
          r.locked = 1'b1;
          r.owner = shadow_owner[hit];
        end else begin
          r.owner = shadow_owner[hit];
          shadow_valid[hit] = 1'b0;
        end
      end
      default: begin
        if (hit >= 0) begin
          r.locked = 1'b1;
          r.owner = shadow_owner[hit];
        end
      end
    endcase
    return r;
  endfunction

  // Holder of an object as {held, owner}
  function automatic logic [SessW:0] lookup_holder(logic [ObjW-1:0] obj);
    for (int i = 0; i < Entries; i++) begin
      if (shadow_valid[i] && shadow_obj[i] == obj) return {1'b1, shadow_owner[i]};
    end
    return '0;
  endfunction

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Offer one item, wait for its acceptance, then record its expected result
  task automatic send_item(logic [FuncW-1:0] fn, logic [ObjW-1:0] obj,
                           logic [SessW-1:0] sess, bit fixed, lock_result_t fixed_res);
    int unsigned gap;
    lock_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW - InRawW){1'b0}}, sess, obj, fn};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    r = apply_lock_request(fn, obj, sess);
    pending_results.push_back(fixed ? fixed_res : r);
    items_sent++;
    quiet = ((items_sent / 100) % 4) == 3;
    if (items_sent == HoldOffAtItem) hold_req = 1'b1;
  endtask

  // Build one random request for the given phase of the run
  task automatic send_random(stim_phase_e phase);
    logic [FuncW-1:0] fn;
    logic [ObjW-1:0]  obj;
    logic [SessW-1:0] sess;
    logic [SessW:0]   held;
    int unsigned      r;
    r = $urandom_range(0, 99);
    obj = obj_pool[$urandom_range(0, PoolObjs - 1)];
    sess = sess_pool[$urandom_range(0, PoolSess - 1)];
    case (phase)
      PH_FILL: begin
        fn = (r < 85) ? FN_LOCK : (r < 95) ? FN_QUERY : FuncUnused;
        obj = obj_pool[fill_idx % PoolObjs];
        fill_idx++;
      end
      PH_CHURN: begin
        if (r < 35) fn = FN_LOCK;
        else if (r < 70) fn = FN_UNLOCK;
        else if (r < 90) fn = FN_QUERY;
        else if (r < 95) fn = FuncUnused;
        else begin
          fn = FuncW'($urandom_range(0, 3));
          obj = $urandom;
          sess = {$urandom, $urandom};
        end
      end
      default: begin
        fn = (r < 80) ? FN_UNLOCK : (r < 90) ? FN_LOCK : FN_QUERY;
      end
    endcase
    // Use the actual holder often so that unlocks and relocks succeed
    held = lookup_holder(obj);
    if (held[SessW] && (fn == FN_LOCK || fn == FN_UNLOCK) &&
        (phase == PH_DRAIN || $urandom_range(0, 1) == 1)) begin
      sess = held[SessW-1:0];
    end
    send_item(fn, obj, sess, 1'b0, '{ST_SUCCESS, 1'b0, '0});
  endtask

  // Drive the output ready: random stalls plus one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each result item with the oldest expectation
  always @(negedge clk_i) begin
    lock_result_t e;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: tdata %h", m_axis_tdata);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
          err_count++;
        end
        if (m_axis_tdata[2] !== e.locked) begin
          $error("locked: expected %0d, got %0d", e.locked, m_axis_tdata[2]);
          err_count++;
        end
        if (m_axis_tdata[66:3] !== e.owner) begin
          $error("owner_session: expected %h, got %h", e.owner, m_axis_tdata[66:3]);
          err_count++;
        end
      end
    end
  end

  // Stop the run when no item moves on either side for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    do begin
      @(negedge clk_i);
      if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end while (idle_cycles < IdleLimit);
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    for (int i = 0; i < Entries; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_obj[i] = '0;
      shadow_owner[i] = '0;
    end
    for (int i = 0; i < PoolObjs; i++) obj_pool[i] = $urandom;
    for (int i = 0; i < PoolSess; i++) sess_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    foreach (lock_rows[i]) begin
      send_item(lock_rows[i].fn, lock_rows[i].obj, lock_rows[i].sess,
                lock_rows[i].fixed, lock_rows[i].res);
    end

    // Fill past capacity so that locks hit a full table, then churn and drain
    repeat (FillItems) send_random(PH_FILL);
    repeat (ChurnItems) send_random(PH_CHURN);
    repeat (DrainItems) send_random(PH_DRAIN);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2 * SearchCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
